// ===== src/entsp_pkg.sv =====
`timescale 1ns / 1ps

package entsp_pkg;

  // Default stack depth of the parser
  localparam int unsigned DEF_MAX_DEPTH = 16;

  // Event kinds
  localparam logic [1:0] EV_NONE  = 2'd0;
  localparam logic [1:0] EV_DATA  = 2'd1;
  localparam logic [1:0] EV_START = 2'd2;
  localparam logic [1:0] EV_END   = 2'd3;

  // Error codes
  localparam logic [2:0] ERR_OK        = 3'd0;
  localparam logic [2:0] ERR_ESC_END   = 3'd1;
  localparam logic [2:0] ERR_UNMATCHED = 3'd2;
  localparam logic [2:0] ERR_UNCLOSED  = 3'd3;
  localparam logic [2:0] ERR_OVERFLOW  = 3'd4;

  // Configuration register indexes
  localparam logic [1:0] CFG_START_MARKER  = 2'd0;
  localparam logic [1:0] CFG_END_MARKER    = 2'd1;
  localparam logic [1:0] CFG_ESCAPE_MARKER = 2'd2;

  // Configuration reset values
  localparam logic [7:0] RST_START_MARKER  = 8'd254;
  localparam logic [7:0] RST_END_MARKER    = 8'd255;
  localparam logic [7:0] RST_ESCAPE_MARKER = 8'd253;

  typedef struct packed {
    logic [7:0] raw_byte;
    logic       stream_last;
  } in_item_t;

  typedef struct packed {
    logic [1:0] event_kind;
    logic [7:0] data_value;
    logic [7:0] node_kind;
    logic [4:0] nest_level;
    logic [2:0] error_code;
  } out_item_t;

endpackage

// ===== src/entsp_ram.sv =====
`timescale 1ns / 1ps

module entsp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== src/escaped_node_tree_stream_parser.sv =====
`timescale 1ns / 1ps

// Channel | Dir | Handshake              | Payload
// --------+-----+------------------------+-----------------------------------
// in_     | in  | in_valid / in_stall    | in_item_t  (raw_byte, stream_last)
// out_    | out | out_valid / out_stall  | out_item_t (event, data, node, ...)
// cfg_    | in  | cfg_valid / cfg_ready  | cfg_index (2b), cfg_data (8b)
//
// One byte is accepted per cycle while in_stall is low, and its result is registered in
// the output register; a pop does not wait on a RAM read since the top of stack is held
// in a register and the entry below it is prefetched from the stack RAM.
// Synchronous reset clears phase, open count and both output slots and restores the
// markers; the stack RAM is not cleared. A stalled result holds in the output
// register, a second one parks in a skid register, and in_stall is high while it is full.

module escaped_node_tree_stream_parser
  import entsp_pkg::*;
#(
  parameter int unsigned MAX_DEPTH = DEF_MAX_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  localparam int unsigned CW = $clog2(MAX_DEPTH + 1);
  localparam int unsigned AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_DEPTH);

  // Parse phase codes; the unused code behaves as normal
  localparam logic [1:0] PH_NORMAL  = 2'd0;
  localparam logic [1:0] PH_ESCAPED = 2'd1;
  localparam logic [1:0] PH_TYPE    = 2'd2;

  logic [7:0]    start_mk_r, end_mk_r, esc_mk_r;
  logic [1:0]    phase_r, phase_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt, cnt_evt;
  logic [7:0]    top_r, top_nxt;
  logic [7:0]    below_top;

  logic          out_valid_r, skid_valid_r;
  out_item_t     out_r, skid_r;

  logic          in_acc;
  logic          emit;
  out_item_t     res;
  logic          wr_en;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid_r;
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Marker registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_mk_r <= RST_START_MARKER;
      end_mk_r   <= RST_END_MARKER;
      esc_mk_r   <= RST_ESCAPE_MARKER;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_START_MARKER:  start_mk_r <= cfg_data;
        CFG_END_MARKER:    end_mk_r   <= cfg_data;
        CFG_ESCAPE_MARKER: esc_mk_r   <= cfg_data;
        default: ;  // writes past the register list are dropped
      endcase
    end
  end

  // Decode one byte. cnt_evt is the count reported with the event; cnt_nxt
  // additionally applies the stream-end reset.
  always_comb begin
    phase_nxt = phase_r;
    cnt_evt   = cnt_r;
    top_nxt   = top_r;
    wr_en     = 1'b0;
    emit      = 1'b0;
    res       = '0;
    if (in_acc) begin
      unique case (phase_r)
        PH_ESCAPED: begin
          phase_nxt      = PH_NORMAL;
          res.event_kind = EV_DATA;
          res.data_value = in_data.raw_byte;
          emit           = 1'b1;
        end
        PH_TYPE: begin
          phase_nxt     = PH_NORMAL;
          res.node_kind = in_data.raw_byte;
          emit          = 1'b1;
          if (cnt_r < CNT_MAX) begin
            // Push: the new byte becomes the top, and is also stored in RAM
            wr_en          = 1'b1;
            top_nxt        = in_data.raw_byte;
            cnt_evt        = cnt_r + CW'(1);
            res.event_kind = EV_START;
          end else begin
            // Drop the node; its end marker will close the enclosing node
            res.error_code = ERR_OVERFLOW;
          end
        end
        default: begin
          phase_nxt = PH_NORMAL;
          if (in_data.raw_byte == esc_mk_r) begin
            phase_nxt = PH_ESCAPED;
            if (in_data.stream_last) begin
              res.error_code = ERR_ESC_END;
              emit           = 1'b1;
            end
          end else if (in_data.raw_byte == start_mk_r) begin
            phase_nxt = PH_TYPE;
            if (in_data.stream_last) begin
              res.error_code = ERR_UNCLOSED;
              emit           = 1'b1;
            end
          end else if (in_data.raw_byte == end_mk_r) begin
            emit = 1'b1;
            if (cnt_r == '0) begin
              res.error_code = ERR_UNMATCHED;
            end else begin
              // Pop: the prefetched entry below the top becomes the new top
              cnt_evt        = cnt_r - CW'(1);
              res.event_kind = EV_END;
              res.node_kind  = top_r;
              top_nxt        = below_top;
            end
          end else begin
            res.event_kind = EV_DATA;
            res.data_value = in_data.raw_byte;
            emit           = 1'b1;
          end
        end
      endcase
      if (in_data.stream_last && res.error_code == ERR_OK && cnt_evt != '0) begin
        res.error_code = ERR_UNCLOSED;
        emit           = 1'b1;
      end
      res.nest_level = 5'(cnt_evt);
    end
    cnt_nxt = cnt_evt;
    if (in_acc && in_data.stream_last) begin
      phase_nxt = PH_NORMAL;
      cnt_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_NORMAL;
      cnt_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
    end
    top_r <= top_nxt;
  end

  // Stack storage: entry k holds the type of the node at depth k+1. The read
  // port always fetches the entry below the next top, so a pop in the very
  // next cycle finds it registered.
  logic [CW-1:0] rd_ptr;
  assign rd_ptr = cnt_nxt - CW'(2);

  entsp_ram #(
    .WIDTH (8),
    .DEPTH (MAX_DEPTH),
    .AW    (AW)
  ) u_stack (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (cnt_r[AW-1:0]),
    .wr_data (in_data.raw_byte),
    .rd_addr (rd_ptr[AW-1:0]),
    .rd_data (below_top)
  );

  // Output register and skid register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || !out_stall) begin
      if (skid_valid_r) begin
        // Advance the parked result; no byte is accepted while it is parked
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= emit;
      end
    end else if (emit) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || !out_stall) begin
      out_r <= skid_valid_r ? skid_r : res;
    end else if (emit) begin
      skid_r <= res;
    end
  end

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register holds a result while the output slot is empty");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_MAX)
    else $error("open node count above stack depth");

  a_stream_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_data.stream_last |=> cnt_r == '0 && phase_r == PH_NORMAL)
    else $error("parser state not cleared after final byte");

  a_start_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.event_kind == EV_START |->
      out_r.error_code == ERR_OK || out_r.error_code == ERR_UNCLOSED)
    else $error("node start transaction carries an impossible error");
`endif

endmodule
